FILE: rtl/core/gzhs_pkg.sv
package gzhs_pkg;

  localparam logic [7:0] ID1_BYTE = 8'h1f;
  localparam logic [7:0] ID2_BYTE = 8'h8b;
  localparam logic [7:0] CM_DEFLATE = 8'd8;

  localparam logic [7:0] FLG_FHCRC = 8'h02;
  localparam logic [7:0] FLG_FEXTRA = 8'h04;
  localparam logic [7:0] FLG_FNAME = 8'h08;
  localparam logic [7:0] FLG_FCOMMENT = 8'h10;

  localparam logic [3:0] HF_HCRC = 4'h1;
  localparam logic [3:0] HF_EXTRA = 4'h2;
  localparam logic [3:0] HF_NAME = 4'h4;
  localparam logic [3:0] HF_COMMENT = 4'h8;

  localparam logic [15:0] FIXED_LEN = 16'd6;
  localparam logic [15:0] HCRC_LEN = 16'd2;

  typedef enum logic [13:0] {
    PH_ID1     = 14'b00000000000001,
    PH_ID2     = 14'b00000000000010,
    PH_CM      = 14'b00000000000100,
    PH_FLG     = 14'b00000000001000,
    PH_FIXED   = 14'b00000000010000,
    PH_XLO     = 14'b00000000100000,
    PH_XHI     = 14'b00000001000000,
    PH_XDATA   = 14'b00000010000000,
    PH_NAME    = 14'b00000100000000,
    PH_COMMENT = 14'b00001000000000,
    PH_HCRC    = 14'b00010000000000,
    PH_PAYLOAD = 14'b00100000000000,
    PH_ERROR   = 14'b01000000000000,
    PH_TRUNC   = 14'b10000000000000
  } phase_t;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_PAYLOAD = 2'd1,
    ST_BAD     = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } feed_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
  } result_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] remaining;
    logic [7:0]  length_low;
    logic [3:0]  header_flags;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_ID1, remaining: 16'd0, length_low: 8'd0, header_flags: 4'd0
  };

endpackage

FILE: rtl/core/gzhs_parse.sv
module gzhs_parse
  import gzhs_pkg::*;
(
  input  parse_state_t state,
  input  feed_item_t   item,
  output parse_state_t state_next,
  output result_item_t res
);

  function automatic phase_t next_section(input logic [3:0] pending);
    phase_t ph;
    if ((pending & HF_EXTRA) != 4'd0) begin
      ph = PH_XLO;
    end else if ((pending & HF_NAME) != 4'd0) begin
      ph = PH_NAME;
    end else if ((pending & HF_COMMENT) != 4'd0) begin
      ph = PH_COMMENT;
    end else if ((pending & HF_HCRC) != 4'd0) begin
      ph = PH_HCRC;
    end else begin
      ph = PH_PAYLOAD;
    end
    return ph;
  endfunction

  parse_state_t cur;
  parse_state_t nxt;
  status_t      status;
  logic         cnt_done;
  logic [15:0]  xlen;

  always_comb begin
    cur = item.first ? STATE_RESET : state;
    nxt = cur;
    status = ST_HEADER;
    cnt_done = (cur.remaining <= 16'd1);
    xlen = {item.data_byte, cur.length_low};

    unique case (cur.phase)
      PH_ID1: begin
        nxt.phase = (item.data_byte == ID1_BYTE) ? PH_ID2 : PH_ERROR;
      end
      PH_ID2: begin
        nxt.phase = (item.data_byte == ID2_BYTE) ? PH_CM : PH_ERROR;
      end
      PH_CM: begin
        nxt.phase = (item.data_byte == CM_DEFLATE) ? PH_FLG : PH_ERROR;
      end
      PH_FLG: begin
        nxt.header_flags = ((item.data_byte & FLG_FHCRC) != 8'd0 ? HF_HCRC : 4'd0)
                         | ((item.data_byte & FLG_FEXTRA) != 8'd0 ? HF_EXTRA : 4'd0)
                         | ((item.data_byte & FLG_FNAME) != 8'd0 ? HF_NAME : 4'd0)
                         | ((item.data_byte & FLG_FCOMMENT) != 8'd0 ? HF_COMMENT : 4'd0);
        nxt.remaining = FIXED_LEN;
        nxt.phase = PH_FIXED;
      end
      PH_FIXED: begin
        if (cnt_done) begin
          nxt.remaining = 16'd0;
          nxt.phase = next_section(cur.header_flags);
        end else begin
          nxt.remaining = cur.remaining - 16'd1;
        end
      end
      PH_XLO: begin
        nxt.length_low = item.data_byte;
        nxt.phase = PH_XHI;
      end
      PH_XHI: begin
        nxt.remaining = xlen;
        if (xlen == 16'd0) begin
          nxt.phase = next_section(cur.header_flags & ~HF_EXTRA);
        end else begin
          nxt.phase = PH_XDATA;
        end
      end
      PH_XDATA: begin
        if (cnt_done) begin
          nxt.remaining = 16'd0;
          nxt.phase = next_section(cur.header_flags & ~HF_EXTRA);
        end else begin
          nxt.remaining = cur.remaining - 16'd1;
        end
      end
      PH_NAME: begin
        if (item.data_byte == 8'd0) begin
          nxt.phase = next_section(cur.header_flags & (HF_COMMENT | HF_HCRC));
        end
      end
      PH_COMMENT: begin
        if (item.data_byte == 8'd0) begin
          nxt.phase = next_section(cur.header_flags & HF_HCRC);
        end
      end
      PH_HCRC: begin
        if (cnt_done) begin
          nxt.remaining = 16'd0;
          nxt.phase = PH_PAYLOAD;
        end else begin
          nxt.remaining = cur.remaining - 16'd1;
        end
      end
      PH_PAYLOAD: begin
        status = ST_PAYLOAD;
      end
      PH_TRUNC: begin
        status = ST_TRUNC;
      end
      default: begin
        nxt.phase = PH_ERROR;
      end
    endcase

    // entering the crc section always starts a two byte count
    if (nxt.phase == PH_HCRC && cur.phase != PH_HCRC) begin
      nxt.remaining = HCRC_LEN;
    end

    if (nxt.phase == PH_ERROR) begin
      status = ST_BAD;
    end else if (status == ST_HEADER && item.last && nxt.phase != PH_PAYLOAD) begin
      nxt.phase = PH_TRUNC;
      status = ST_TRUNC;
    end

    state_next = nxt;
    res.out_byte = item.data_byte;
    res.status = status;
  end

endmodule

FILE: rtl/core/gzip_header_skipper.sv
// channel  direction  handshake                  payload
// feed     in         feed_valid / feed_stall      feed   (data_byte, first, last)
// result   out        result_valid / result_stall  result (out_byte, status)
//
// one item per cycle sustained while result_stall is low; each item gives one
// result, through an input register, the header parser and the result register
// the parser state updates only as an item moves into the result register
// rst is synchronous and clears the valids and puts the parser at the first magic byte
// feed_stall rises only while both registers are full and result_stall is high
module gzip_header_skipper
  import gzhs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         feed_valid,
  output logic         feed_stall,
  input  feed_item_t   feed,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  logic         s1_valid;
  feed_item_t   s1_item;
  parse_state_t state;
  parse_state_t state_next;
  result_item_t res_next;
  logic         advance;

  gzhs_parse u_parse (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .res        (res_next)
  );

  assign advance = s1_valid && (!result_valid || !result_stall);
  assign feed_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!feed_stall) begin
      s1_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!feed_stall && feed_valid) begin
      s1_item <= feed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      state <= STATE_RESET;
    end else if (advance) begin
      result_valid <= 1'b1;
      state <= state_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

endmodule

FILE: rtl/core/gzhs_checker.sv
module gzhs_checker
  import gzhs_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         feed_valid,
  input logic         feed_stall,
  input feed_item_t   feed,
  input logic         result_valid,
  input logic         result_stall,
  input result_item_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    feed_stall |-> result_valid && result_stall)
    else $error("feed stalled without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    feed_valid && !feed_stall ##1 !result_stall |=> result_valid)
    else $error("taken item did not reach the result register");

  a_payload_echo: assert property (@(posedge clk) disable iff (rst)
    feed_valid && !feed_stall && !result_stall ##1 !result_stall
      |=> result.out_byte == $past(feed.data_byte, 2))
    else $error("result byte does not echo the item");

endmodule

bind gzip_header_skipper gzhs_checker u_gzhs_checker (.*);

FILE: bench/gzip_header_skipper_test.sv
module gzip_header_skipper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gzhs_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 300;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PRINT_CAP = 20;

  typedef enum int {
    MEMBER_GOOD,
    MEMBER_CUT,
    MEMBER_BAD_ID,
    MEMBER_DROPPED,
    LINE_NOISE
  } plan_kind_t;

  class header_scoreboard;
    phase_t phase;
    logic [15:0] remaining;
    logic [7:0] xlen_low;
    logic [3:0] flags;
    result_item_t pending[$];
    int errors;
    int checked;
    int status_count[4];

    function new();
      restart();
    endfunction

    function void restart();
      phase = PH_ID1;
      remaining = '0;
      xlen_low = '0;
      flags = '0;
    endfunction

    function phase_t after_section(phase_t done);
      if (done < PH_XLO && (flags & HF_EXTRA) != 0) return PH_XLO;
      if (done < PH_NAME && (flags & HF_NAME) != 0) return PH_NAME;
      if (done < PH_COMMENT && (flags & HF_COMMENT) != 0) return PH_COMMENT;
      if (done < PH_HCRC && (flags & HF_HCRC) != 0) begin
        remaining = HCRC_LEN;
        return PH_HCRC;
      end
      return PH_PAYLOAD;
    endfunction

    function bit counted_out();
      if (remaining <= 16'd1) begin
        remaining = '0;
        return 1'b1;
      end
      remaining = remaining - 16'd1;
      return 1'b0;
    endfunction

    function void note_feed(feed_item_t it);
      status_t st;
      result_item_t r;
      logic [7:0] b;
      b = it.data_byte;
      st = ST_HEADER;
      if (it.first) restart();
      case (phase)
        PH_ID1: phase = (b == ID1_BYTE) ? PH_ID2 : PH_ERROR;
        PH_ID2: phase = (b == ID2_BYTE) ? PH_CM : PH_ERROR;
        PH_CM: phase = (b == CM_DEFLATE) ? PH_FLG : PH_ERROR;
        PH_FLG: begin
          flags = ((b & FLG_FHCRC) != 0 ? HF_HCRC : 4'h0) |
                  ((b & FLG_FEXTRA) != 0 ? HF_EXTRA : 4'h0) |
                  ((b & FLG_FNAME) != 0 ? HF_NAME : 4'h0) |
                  ((b & FLG_FCOMMENT) != 0 ? HF_COMMENT : 4'h0);
          remaining = FIXED_LEN;
          phase = PH_FIXED;
        end
        PH_FIXED: if (counted_out()) phase = after_section(PH_FIXED);
        PH_XLO: begin
          xlen_low = b;
          phase = PH_XHI;
        end
        PH_XHI: begin
          remaining = {b, xlen_low};
          phase = (remaining == 16'd0) ? after_section(PH_XDATA) : PH_XDATA;
        end
        PH_XDATA: if (counted_out()) phase = after_section(PH_XDATA);
        PH_NAME: if (b == 8'd0) phase = after_section(PH_NAME);
        PH_COMMENT: if (b == 8'd0) phase = after_section(PH_COMMENT);
        PH_HCRC: if (counted_out()) phase = after_section(PH_HCRC);
        PH_PAYLOAD: st = ST_PAYLOAD;
        PH_TRUNC: st = ST_TRUNC;
        default: phase = PH_ERROR;
      endcase
      if (phase == PH_ERROR) begin
        st = ST_BAD;
      end else if (st == ST_HEADER && it.last && phase != PH_PAYLOAD) begin
        phase = PH_TRUNC;
        st = ST_TRUNC;
      end
      r.out_byte = b;
      r.status = st;
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    task check_result(result_item_t got);
      result_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with no item waiting", checked));
      end else begin
        want = pending.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("result %0d: byte %h, expected %h", checked, got.out_byte,
                           want.out_byte));
        if (got.status !== want.status)
          report($sformatf("result %0d: status %0d, expected %0d", checked, got.status,
                           want.status));
        status_count[want.status]++;
      end
      checked++;
    endtask

    task check_leftovers();
      if (pending.size() != 0)
        report($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic feed_valid = 1'b0;
  logic feed_stall;
  feed_item_t feed = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_item_t result;

  header_scoreboard sb = new();
  feed_item_t feed_plan[$];
  int kind_count[5];
  int quiet_cycles = 0;
  bit feed_steady = 1'b0;
  bit drain_steady = 1'b0;
  bit hold_done = 1'b0;

  gzip_header_skipper uut (
    .clk(clk),
    .rst(rst),
    .feed_valid(feed_valid),
    .feed_stall(feed_stall),
    .feed(feed),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic logic [7:0] nonzero_byte();
    logic [31:0] r;
    r = $urandom_range(1, 255);
    return r[7:0];
  endfunction

  function automatic int pick_gap(inout bit steady);
    int r;
    if ($urandom_range(63) == 0) steady = !steady;
    if (steady) return 0;
    r = $urandom_range(19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_byte(logic [7:0] b, bit f, bit l);
    feed_item_t it;
    it.data_byte = b;
    it.first = f;
    it.last = l;
    feed_plan.push_back(it);
  endfunction

  function automatic void plan_member(plan_kind_t kind);
    logic [7:0] hdr[$];
    logic [7:0] flg;
    logic [7:0] flip;
    logic [15:0] xlen;
    int n;
    int cut;
    int pos;
    int pay;
    int mid;
    kind_count[kind]++;
    if (kind == LINE_NOISE) begin
      repeat ($urandom_range(1, 4))
        queue_byte(rand_byte(), $urandom_range(3) == 0, $urandom_range(3) == 0);
      return;
    end
    flg = rand_byte();
    hdr.push_back(ID1_BYTE);
    hdr.push_back(ID2_BYTE);
    hdr.push_back(CM_DEFLATE);
    hdr.push_back(flg);
    repeat (6) hdr.push_back(rand_byte());
    if ((flg & FLG_FEXTRA) != 0) begin
      case ($urandom_range(19))
        0, 1: xlen = 16'd0;
        2: xlen = 16'($urandom_range(255, 300));
        3: xlen = (kind == MEMBER_GOOD) ? 16'd1 : 16'($urandom_range(65535));
        default: xlen = 16'($urandom_range(1, 6));
      endcase
      hdr.push_back(xlen[7:0]);
      hdr.push_back(xlen[15:8]);
      n = (kind != MEMBER_GOOD && xlen > 16'd40) ? 40 : int'(xlen);
      repeat (n) hdr.push_back(rand_byte());
    end
    if ((flg & FLG_FNAME) != 0) begin
      repeat ($urandom_range(5)) hdr.push_back(nonzero_byte());
      hdr.push_back(8'd0);
    end
    if ((flg & FLG_FCOMMENT) != 0) begin
      repeat ($urandom_range(5)) hdr.push_back(nonzero_byte());
      hdr.push_back(8'd0);
    end
    if ((flg & FLG_FHCRC) != 0) repeat (2) hdr.push_back(rand_byte());
    case (kind)
      MEMBER_GOOD: begin
        pay = $urandom_range(0, 12);
        for (int i = 0; i < hdr.size(); i++)
          queue_byte(hdr[i], i == 0, pay == 0 && i == hdr.size() - 1);
        mid = ($urandom_range(3) == 0) ? $urandom_range(0, 11) : -1;
        for (int i = 0; i < pay; i++) queue_byte(rand_byte(), 1'b0, i == pay - 1 || i == mid);
      end
      MEMBER_CUT: begin
        cut = $urandom_range(hdr.size() - 2);
        for (int i = 0; i <= cut; i++) queue_byte(hdr[i], i == 0, i == cut);
        repeat ($urandom_range(3)) queue_byte(rand_byte(), 1'b0, $urandom_range(1) == 1);
      end
      MEMBER_BAD_ID: begin
        pos = $urandom_range(2);
        flip = nonzero_byte();
        hdr[pos] = hdr[pos] ^ flip;
        n = $urandom_range(pos, hdr.size() - 1);
        for (int i = 0; i <= n; i++)
          queue_byte(hdr[i], i == 0, i == n && $urandom_range(1) == 1);
        repeat ($urandom_range(3)) queue_byte(rand_byte(), 1'b0, $urandom_range(1) == 1);
      end
      default: begin
        cut = $urandom_range(hdr.size() - 2);
        for (int i = 0; i <= cut; i++) queue_byte(hdr[i], i == 0, 1'b0);
      end
    endcase
  endfunction

  function automatic void plan_stream();
    int goal;
    int r;
    // minimal header, fixed bytes at both extremes, then payload
    queue_byte(ID1_BYTE, 1'b1, 1'b0);
    queue_byte(ID2_BYTE, 1'b0, 1'b0);
    queue_byte(CM_DEFLATE, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) queue_byte(i[0] ? 8'hff : 8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b1);
    // bad first magic byte together with last
    queue_byte(8'h00, 1'b1, 1'b1);
    // empty extra field with text and reserved flag bits set
    queue_byte(ID1_BYTE, 1'b1, 1'b0);
    queue_byte(ID2_BYTE, 1'b0, 1'b0);
    queue_byte(CM_DEFLATE, 1'b0, 1'b0);
    queue_byte(8'he5, 1'b0, 1'b0);
    repeat (6) queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b1);
    goal = feed_plan.size() + RANDOM_ITEMS;
    while (feed_plan.size() < goal) begin
      r = $urandom_range(99);
      if (r < 60) plan_member(MEMBER_GOOD);
      else if (r < 72) plan_member(MEMBER_CUT);
      else if (r < 82) plan_member(MEMBER_BAD_ID);
      else if (r < 88) plan_member(MEMBER_DROPPED);
      else plan_member(LINE_NOISE);
    end
  endfunction

  task automatic drive_feed();
    int g;
    foreach (feed_plan[i]) begin
      g = pick_gap(feed_steady);
      if (g > 0) begin
        feed_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      feed_valid <= 1'b1;
      feed <= feed_plan[i];
      @(posedge clk);
      while (feed_stall) @(posedge clk);
    end
    feed_valid <= 1'b0;
  endtask

  task automatic drain_results();
    int g;
    forever begin
      if (!hold_done && sb.checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        g = HOLD_CYCLES;
      end else begin
        g = pick_gap(drain_steady);
      end
      if (g > 0) begin
        result_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && feed_valid && !feed_stall) sb.note_feed(feed);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    if (!rst && ((feed_valid && !feed_stall) || (result_valid && !result_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (rst) @(posedge clk);
    drain_results();
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    plan_stream();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drive_feed();
    // let the monitor record the last item taken
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.check_leftovers();
    $display("sent %0d items: %0d good streams, %0d cut short, %0d bad id, %0d dropped, %0d noise",
             feed_plan.size(), kind_count[MEMBER_GOOD], kind_count[MEMBER_CUT],
             kind_count[MEMBER_BAD_ID], kind_count[MEMBER_DROPPED], kind_count[LINE_NOISE]);
    $display("checked %0d results: %0d header, %0d payload, %0d bad, %0d truncated, %0d errors",
             sb.checked, sb.status_count[ST_HEADER], sb.status_count[ST_PAYLOAD],
             sb.status_count[ST_BAD], sb.status_count[ST_TRUNC], sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
